FILE: src/assert_macros.svh
// Assertion helpers included by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq implication check failed");
`define RMQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq next-cycle check failed");
`else
`define RMQ_ASSERT_IMPLY(name, ante, cons)
`define RMQ_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: src/rmq_pkg.sv
package rmq_pkg;

    localparam int ELEM_W = 16;
    localparam int QUAT_MAX = 32767;
    localparam int QUAT_MIN_MAG = 32768;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t m00;
        elem_t m01;
        elem_t m02;
        elem_t m10;
        elem_t m11;
        elem_t m12;
        elem_t m20;
        elem_t m21;
        elem_t m22;
    } matrix_t;

    typedef struct packed {
        elem_t quat_x;
        elem_t quat_y;
        elem_t quat_z;
        elem_t quat_w;
        logic  degenerate;
    } quat_t;

endpackage

FILE: src/rmq_mat_if.sv
interface rmq_mat_if;
    logic             valid;
    logic             ready;
    rmq_pkg::matrix_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/rmq_quat_if.sv
interface rmq_quat_if;
    logic           valid;
    logic           ready;
    rmq_pkg::quat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/rmq_div_lane.sv
module rmq_div_lane #(
    parameter int FRAC_BITS = 14,
    parameter int VW = 19
) (
    input  logic                 clk,
    input  logic [FRAC_BITS+1:0] ce,
    input  logic [VW-2:0]        mag,
    input  logic [VW-1:0]        len,
    output logic [FRAC_BITS:0]   q
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = VW + FRAC_BITS + 1;
    localparam int DW = VW + 1;

    logic [NW-1:0] num;
    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] nlo_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic [DW-1:0] d_reg   [0:QW];

    assign num = (NW'(mag) << (FRAC_BITS + 1)) + NW'(len);

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            rem_reg[0] <= DW'(num[NW-1:QW]);
            nlo_reg[0] <= num[QW-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= {len, 1'b0};
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] rem_next;

        assign trial    = {rem_reg[k-1], nlo_reg[k-1][QW-1]};
        assign ge       = trial >= {1'b0, d_reg[k-1]};
        assign diff     = trial - {1'b0, d_reg[k-1]};
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge clk)
        begin
            if (ce[k])
            begin
                rem_reg[k] <= rem_next;
                nlo_reg[k] <= {nlo_reg[k-1][QW-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
            end
        end
    end

    assign q = q_reg[QW];

endmodule

FILE: src/rotation_matrix_to_quaternion_core.sv
// Pipeline depth is set by one square-root stage per root bit and one divider
// stage per quotient bit.
// Throughput: one word per cycle; a stalled output holds the pipe without loss.
// Reset clears all stage valid bits asynchronously; data registers are not reset.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    rmq_mat_if.sink          matrix,
    rmq_quat_if.source       quat
);

    localparam int VW  = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
    localparam int SW  = 2 * VW;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NSQ = VW;
    localparam int ST_DIV = 3 + NSQ;
    localparam int NS  = 3 + NSQ + QW + 2;
    localparam int EW  = ((QW > 16) ? QW : 16) + 1;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] ce;

    logic signed [VW-1:0]  vp_reg [0:NSQ+2][4];
    logic [2*VW-3:0]       sq_reg [4];
    logic [SW-1:0]         s_reg  [0:NSQ];
    logic [SW-1:0]         rt_reg [1:NSQ];
    logic [4:0]            side_reg [2:NS-2];
    logic [QW-1:0]         q_lane [4];
    rmq_pkg::quat_t        out_reg;

    always_comb
    begin
        ce[NS-1] = !vld_reg[NS-1] || quat.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ce[k] = !vld_reg[k] || ce[k+1];
        end
    end

    assign matrix.ready = ce[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                vld_reg[0] <= matrix.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ce[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    function automatic logic [VW-2:0] mag_of(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] n;
        n = -v;
        return v[VW-1] ? n[VW-2:0] : v[VW-2:0];
    endfunction

    // Case selection and the unnormalized vector.
    logic signed [VW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, one_v;
    logic signed [VW-1:0] v_next [4];

    assign a00 = VW'(matrix.data.m00);
    assign a01 = VW'(matrix.data.m01);
    assign a02 = VW'(matrix.data.m02);
    assign a10 = VW'(matrix.data.m10);
    assign a11 = VW'(matrix.data.m11);
    assign a12 = VW'(matrix.data.m12);
    assign a20 = VW'(matrix.data.m20);
    assign a21 = VW'(matrix.data.m21);
    assign a22 = VW'(matrix.data.m22);
    assign one_v = VW'(1) << FRAC_BITS;

    always_comb
    begin
        if (a22 <= 0)
        begin
            if (a00 >= a11)
            begin
                v_next[0] = one_v + a00 - a11 - a22;
                v_next[1] = a01 + a10;
                v_next[2] = a20 + a02;
                v_next[3] = a12 - a21;
            end
            else
            begin
                v_next[0] = a01 + a10;
                v_next[1] = one_v - a00 + a11 - a22;
                v_next[2] = a12 + a21;
                v_next[3] = a20 - a02;
            end
        end
        else
        begin
            if (a00 <= -a11)
            begin
                v_next[0] = a20 + a02;
                v_next[1] = a12 + a21;
                v_next[2] = one_v - a00 - a11 + a22;
                v_next[3] = a01 - a10;
            end
            else
            begin
                v_next[0] = a12 - a21;
                v_next[1] = a20 - a02;
                v_next[2] = a01 - a10;
                v_next[3] = one_v + a00 + a11 + a22;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            vp_reg[0] <= v_next;
        end
        if (ce[1])
        begin
            vp_reg[1] <= vp_reg[0];
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= (2*VW-2)'(mag_of(vp_reg[0][i])) * (2*VW-2)'(mag_of(vp_reg[0][i]));
            end
        end
        if (ce[2])
        begin
            vp_reg[2] <= vp_reg[1];
            s_reg[0]  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
            side_reg[2] <= {(sq_reg[0] == '0) && (sq_reg[1] == '0) &&
                            (sq_reg[2] == '0) && (sq_reg[3] == '0),
                            vp_reg[1][3][VW-1], vp_reg[1][2][VW-1],
                            vp_reg[1][1][VW-1], vp_reg[1][0][VW-1]};
        end
    end

    for (genvar k = 3; k <= NS - 2; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (ce[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Integer square root, one root bit per stage.
    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        localparam logic [SW-1:0] BIT_C = SW'(1) << (2 * (NSQ - 1 - j));
        logic [SW-1:0] root_in;
        logic [SW-1:0] trial;

        if (j == 0)
        begin : g_first
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign root_in = rt_reg[j];
        end

        assign trial = root_in + BIT_C;

        always_ff @(posedge clk)
        begin
            if (ce[3+j])
            begin
                vp_reg[3+j] <= vp_reg[2+j];
                if (s_reg[j] >= trial)
                begin
                    s_reg[j+1]  <= s_reg[j] - trial;
                    rt_reg[j+1] <= (root_in >> 1) + BIT_C;
                end
                else
                begin
                    s_reg[j+1]  <= s_reg[j];
                    rt_reg[j+1] <= root_in >> 1;
                end
            end
        end
    end

    logic [VW-1:0] len;
    assign len = rt_reg[NSQ][VW-1:0];

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        rmq_div_lane #(
            .FRAC_BITS (FRAC_BITS),
            .VW        (VW)
        ) u_div (
            .clk (clk),
            .ce  (ce[ST_DIV +: QW+1]),
            .mag (mag_of(vp_reg[NSQ+2][i])),
            .len (len),
            .q   (q_lane[i])
        );
    end

    function automatic rmq_pkg::elem_t sat_of(input logic [QW-1:0] q, input logic neg);
        logic [EW-1:0] qx;
        logic [EW-1:0] nq;
        qx = EW'(q);
        nq = -qx;
        if (!neg)
        begin
            return (qx > EW'(rmq_pkg::QUAT_MAX)) ? rmq_pkg::elem_t'(rmq_pkg::QUAT_MAX)
                                                 : qx[15:0];
        end
        return (qx > EW'(rmq_pkg::QUAT_MIN_MAG)) ? 16'sh8000 : nq[15:0];
    endfunction

    logic [4:0] side_out;
    assign side_out = side_reg[NS-2];

    always_ff @(posedge clk)
    begin
        if (ce[NS-1])
        begin
            out_reg.degenerate <= side_out[4];
            out_reg.quat_x <= side_out[4] ? '0 : sat_of(q_lane[0], side_out[0]);
            out_reg.quat_y <= side_out[4] ? '0 : sat_of(q_lane[1], side_out[1]);
            out_reg.quat_z <= side_out[4] ? '0 : sat_of(q_lane[2], side_out[2]);
            out_reg.quat_w <= side_out[4] ? '0 : sat_of(q_lane[3], side_out[3]);
        end
    end

    assign quat.valid = vld_reg[NS-1];
    assign quat.data  = out_reg;

    logic len_ok;
    logic q_ok;
    logic out_zero;
    assign len_ok = (len >= VW'(mag_of(vp_reg[NSQ+2][0]))) &&
                    (len >= VW'(mag_of(vp_reg[NSQ+2][1]))) &&
                    (len >= VW'(mag_of(vp_reg[NSQ+2][2]))) &&
                    (len >= VW'(mag_of(vp_reg[NSQ+2][3])));
    assign q_ok = (q_lane[0] <= QW'(1) << FRAC_BITS) && (q_lane[1] <= QW'(1) << FRAC_BITS) &&
                  (q_lane[2] <= QW'(1) << FRAC_BITS) && (q_lane[3] <= QW'(1) << FRAC_BITS);
    assign out_zero = (quat.data.quat_x == '0) && (quat.data.quat_y == '0) &&
                      (quat.data.quat_z == '0) && (quat.data.quat_w == '0);

    `RMQ_ASSERT_IMPLY(a_len_covers_vector, vld_reg[NSQ+2], len_ok)
    `RMQ_ASSERT_IMPLY(a_quotient_bounded, vld_reg[NS-2] && !side_out[4], q_ok)
    `RMQ_ASSERT_IMPLY(a_degenerate_zero, quat.valid && quat.data.degenerate, out_zero)
    `RMQ_ASSERT_NEXT(a_stall_keeps_last, vld_reg[NS-1] && !quat.ready, vld_reg[NS-1])

endmodule
